@@ sv/tfd_pkg.sv @@
`timescale 1ns / 1ps

package tfd_pkg;

  // position width of the solved coordinates
  localparam int POS_BITS = 24;

  localparam int ANC_W  = 15;            // anchor coordinate
  localparam int LIM_W  = 16;            // distance limits
  localparam int CFG_W  = 16;            // config write data
  localparam int IDX_W  = 3;             // config register index
  localparam int RNG_W  = 17;            // measured range
  localparam int DIF_W  = ANC_W + 2;     // 2*(b - a)
  localparam int SQA_W  = 2 * ANC_W;     // anchor coordinate squared, signed
  localparam int K_W    = SQA_W + 1;     // sum of anchor squares
  localparam int RSQ_W  = 2 * RNG_W;     // range squared, unsigned
  localparam int RD_W   = RSQ_W + 1;     // difference of range squares
  localparam int CF_W   = RD_W + 1;      // right-hand side C / F
  localparam int PR_W   = CF_W + DIF_W;  // C*E style products
  localparam int NUM_W  = PR_W + 1;      // Cramer numerators
  localparam int NMAG_W = NUM_W - 1;     // numerator magnitude
  localparam int DET_W  = 2 * DIF_W + 1; // determinant
  localparam int DMAG_W = DET_W - 1;     // determinant magnitude
  localparam int REM_W  = DMAG_W + POS_BITS;
  localparam int LSQ_W  = 2 * LIM_W;     // squared limits
  localparam int MW     = POS_BITS + 17; // heading products
  localparam int DSQ_W  = 2 * POS_BITS;  // squared distance

  // Q15 band edge constants
  localparam int SIN20_Q15 = 11207;
  localparam int COS20_Q15 = 30792;

  // register indexes
  localparam logic [IDX_W-1:0] REG_AX  = 3'd0;
  localparam logic [IDX_W-1:0] REG_AY  = 3'd1;
  localparam logic [IDX_W-1:0] REG_BX  = 3'd2;
  localparam logic [IDX_W-1:0] REG_BY  = 3'd3;
  localparam logic [IDX_W-1:0] REG_CX  = 3'd4;
  localparam logic [IDX_W-1:0] REG_CY  = 3'd5;
  localparam logic [IDX_W-1:0] REG_FWD = 3'd6;
  localparam logic [IDX_W-1:0] REG_RNG = 3'd7;

  // action codes
  localparam logic [1:0] ACT_HOLD  = 2'd0;
  localparam logic [1:0] ACT_FWD   = 2'd1;
  localparam logic [1:0] ACT_RIGHT = 2'd2;
  localparam logic [1:0] ACT_LEFT  = 2'd3;

  typedef struct packed {
    logic degen;
    logic neg_x;
    logic neg_y;
    logic ovf_x;
    logic ovf_y;
  } tfd_flags_t;

  // saturate an unsigned quotient magnitude with its sign
  function automatic logic signed [POS_BITS-1:0] clamp_pos(
    input logic [POS_BITS-1:0] q,
    input logic                ovf,
    input logic                neg
  );
    logic [POS_BITS-1:0] hi;
    logic [POS_BITS-1:0] mn;
    hi = {1'b0, {(POS_BITS-1){1'b1}}};
    mn = {1'b1, {(POS_BITS-1){1'b0}}};
    if (!neg) begin
      clamp_pos = (ovf || (q > hi)) ? hi : q;
    end else begin
      clamp_pos = (ovf || (q > mn)) ? mn : (~q + 1'b1);
    end
  endfunction

endpackage

@@ sv/trilateration_follow_decision_top.sv @@
`timescale 1ns / 1ps

// Throughput: one request per cycle whenever busy is low; the two restoring dividers resolve
// one quotient bit per stage, which sets the depth.
// Reset (rst, synchronous): anchors and limits return to their defaults, all in-flight
// requests are dropped and busy is high for the cycle after reset. done is a strobe.

module trilateration_follow_decision_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [tfd_pkg::RNG_W-1:0]            range_a,
  input  logic [tfd_pkg::RNG_W-1:0]            range_b,
  input  logic [tfd_pkg::RNG_W-1:0]            range_c,
  input  logic                                 cfg_we,
  input  logic [tfd_pkg::IDX_W-1:0]            cfg_index,
  input  logic [tfd_pkg::CFG_W-1:0]            cfg_data,
  output logic                                 done,
  output logic signed [tfd_pkg::POS_BITS-1:0]  pos_x,
  output logic signed [tfd_pkg::POS_BITS-1:0]  pos_y,
  output logic                                 degenerate,
  output logic                                 beyond_limit,
  output logic [1:0]                           action
);

  localparam int P   = tfd_pkg::POS_BITS;
  localparam int LAT = P + 12;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [tfd_pkg::ANC_W-1:0] anc_ax, anc_ay, anc_bx, anc_by, anc_cx, anc_cy;
  logic [tfd_pkg::LIM_W-1:0]        fwd_lim, rng_lim;

  always_ff @(posedge clk) begin
    if (rst) begin
      anc_ax  <= -15'sd250;
      anc_ay  <= '0;
      anc_bx  <= 15'sd250;
      anc_by  <= '0;
      anc_cx  <= '0;
      anc_cy  <= -15'sd550;
      fwd_lim <= 16'd2500;
      rng_lim <= 16'd10000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tfd_pkg::REG_AX:  anc_ax  <= cfg_data[tfd_pkg::ANC_W-1:0];
        tfd_pkg::REG_AY:  anc_ay  <= cfg_data[tfd_pkg::ANC_W-1:0];
        tfd_pkg::REG_BX:  anc_bx  <= cfg_data[tfd_pkg::ANC_W-1:0];
        tfd_pkg::REG_BY:  anc_by  <= cfg_data[tfd_pkg::ANC_W-1:0];
        tfd_pkg::REG_CX:  anc_cx  <= cfg_data[tfd_pkg::ANC_W-1:0];
        tfd_pkg::REG_CY:  anc_cy  <= cfg_data[tfd_pkg::ANC_W-1:0];
        tfd_pkg::REG_FWD: fwd_lim <= cfg_data[tfd_pkg::LIM_W-1:0];
        tfd_pkg::REG_RNG: rng_lim <= cfg_data[tfd_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Terms that depend on configuration only. They are registered in levels after a
  // write; each is read by the request pipeline no earlier than its own level.
  // ---------------------------------------------------------------------------
  logic signed [tfd_pkg::DIF_W-1:0] k_a, k_b, k_d, k_e;          // level 1
  logic signed [tfd_pkg::SQA_W-1:0] sq_ax, sq_ay, sq_bx, sq_by, sq_cx, sq_cy;
  logic [tfd_pkg::LSQ_W-1:0]        fwd_sq, lim_sq;
  logic signed [tfd_pkg::K_W-1:0]   k_c, k_f;                    // level 2
  logic signed [tfd_pkg::DET_W-1:0] p_ae, p_bd;
  logic signed [tfd_pkg::DET_W-1:0] det_k;                       // level 3
  logic [tfd_pkg::DMAG_W-1:0]       k_dmag;                      // level 4
  logic                             k_dneg, k_degen;

  always_ff @(posedge clk) begin
    k_a    <= (tfd_pkg::DIF_W'(anc_bx) - tfd_pkg::DIF_W'(anc_ax)) <<< 1;
    k_b    <= (tfd_pkg::DIF_W'(anc_by) - tfd_pkg::DIF_W'(anc_ay)) <<< 1;
    k_d    <= (tfd_pkg::DIF_W'(anc_cx) - tfd_pkg::DIF_W'(anc_bx)) <<< 1;
    k_e    <= (tfd_pkg::DIF_W'(anc_cy) - tfd_pkg::DIF_W'(anc_by)) <<< 1;
    sq_ax  <= anc_ax * anc_ax;
    sq_ay  <= anc_ay * anc_ay;
    sq_bx  <= anc_bx * anc_bx;
    sq_by  <= anc_by * anc_by;
    sq_cx  <= anc_cx * anc_cx;
    sq_cy  <= anc_cy * anc_cy;
    fwd_sq <= fwd_lim * fwd_lim;
    lim_sq <= rng_lim * rng_lim;

    k_c  <= tfd_pkg::K_W'(sq_bx) - tfd_pkg::K_W'(sq_ax)
          + tfd_pkg::K_W'(sq_by) - tfd_pkg::K_W'(sq_ay);
    k_f  <= tfd_pkg::K_W'(sq_cx) - tfd_pkg::K_W'(sq_bx)
          + tfd_pkg::K_W'(sq_cy) - tfd_pkg::K_W'(sq_by);
    p_ae <= tfd_pkg::DET_W'(k_a) * tfd_pkg::DET_W'(k_e);
    p_bd <= tfd_pkg::DET_W'(k_b) * tfd_pkg::DET_W'(k_d);

    det_k <= p_ae - p_bd;

    k_dneg  <= det_k[tfd_pkg::DET_W-1];
    k_degen <= (det_k == '0);
    k_dmag  <= det_k[tfd_pkg::DET_W-1] ? tfd_pkg::DMAG_W'(-det_k)
                                       : tfd_pkg::DMAG_W'(det_k);
  end

  // ---------------------------------------------------------------------------
  // Request handshake and valid chain
  // ---------------------------------------------------------------------------
  logic           acc;
  logic [LAT-1:0] vld;

  assign acc  = start && !busy;
  assign done = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      vld  <= '0;
    end else begin
      busy <= 1'b0;
      vld  <= {vld[LAT-2:0], acc};
    end
  end

  // ---------------------------------------------------------------------------
  // Front end: squares, right-hand sides, Cramer numerators
  // ---------------------------------------------------------------------------
  logic [tfd_pkg::RNG_W-1:0]         r_a, r_b, r_c;      // stage 0
  logic [tfd_pkg::RSQ_W-1:0]         q_a, q_b, q_c;      // stage 1
  logic signed [tfd_pkg::RD_W-1:0]   d_ab, d_bc;         // stage 2
  logic signed [tfd_pkg::CF_W-1:0]   cc, ff;             // stage 3
  logic signed [tfd_pkg::PR_W-1:0]   m_ce, m_fb, m_af, m_dc; // stage 4
  logic signed [tfd_pkg::NUM_W-1:0]  n_x, n_y;           // stage 5
  logic [tfd_pkg::NMAG_W-1:0]        mag_x, mag_y;       // stage 6
  logic                              sgn_x, sgn_y;

  always_ff @(posedge clk) begin
    r_a <= range_a;
    r_b <= range_b;
    r_c <= range_c;

    q_a <= r_a * r_a;
    q_b <= r_b * r_b;
    q_c <= r_c * r_c;

    d_ab <= tfd_pkg::RD_W'(q_a) - tfd_pkg::RD_W'(q_b);
    d_bc <= tfd_pkg::RD_W'(q_b) - tfd_pkg::RD_W'(q_c);

    cc <= tfd_pkg::CF_W'(d_ab) + tfd_pkg::CF_W'(k_c);
    ff <= tfd_pkg::CF_W'(d_bc) + tfd_pkg::CF_W'(k_f);

    m_ce <= tfd_pkg::PR_W'(cc) * tfd_pkg::PR_W'(k_e);
    m_fb <= tfd_pkg::PR_W'(ff) * tfd_pkg::PR_W'(k_b);
    m_af <= tfd_pkg::PR_W'(ff) * tfd_pkg::PR_W'(k_a);
    m_dc <= tfd_pkg::PR_W'(cc) * tfd_pkg::PR_W'(k_d);

    n_x <= tfd_pkg::NUM_W'(m_ce) - tfd_pkg::NUM_W'(m_fb);
    n_y <= tfd_pkg::NUM_W'(m_af) - tfd_pkg::NUM_W'(m_dc);

    mag_x <= n_x[tfd_pkg::NUM_W-1] ? tfd_pkg::NMAG_W'(-n_x) : tfd_pkg::NMAG_W'(n_x);
    mag_y <= n_y[tfd_pkg::NUM_W-1] ? tfd_pkg::NMAG_W'(-n_y) : tfd_pkg::NMAG_W'(n_y);
    sgn_x <= n_x[tfd_pkg::NUM_W-1] ^ k_dneg;
    sgn_y <= n_y[tfd_pkg::NUM_W-1] ^ k_dneg;
  end

  // ---------------------------------------------------------------------------
  // Dividers: overflow check, then one restoring step per stage, MSB first.
  // A quotient of 2^P or more saturates whatever the sign.
  // ---------------------------------------------------------------------------
  logic [tfd_pkg::REM_W-1:0] rem_x [0:P];
  logic [tfd_pkg::REM_W-1:0] rem_y [0:P];
  logic [P-1:0]              quo_x [0:P];
  logic [P-1:0]              quo_y [0:P];
  tfd_pkg::tfd_flags_t       flg   [0:P];

  always_ff @(posedge clk) begin
    rem_x[0]       <= tfd_pkg::REM_W'(mag_x);
    rem_y[0]       <= tfd_pkg::REM_W'(mag_y);
    quo_x[0]       <= '0;
    quo_y[0]       <= '0;
    flg[0].degen   <= k_degen;
    flg[0].neg_x   <= sgn_x;
    flg[0].neg_y   <= sgn_y;
    flg[0].ovf_x   <= tfd_pkg::REM_W'(mag_x) >= (tfd_pkg::REM_W'(k_dmag) << P);
    flg[0].ovf_y   <= tfd_pkg::REM_W'(mag_y) >= (tfd_pkg::REM_W'(k_dmag) << P);
  end

  for (genvar i = 0; i < P; i++) begin : g_div
    logic [tfd_pkg::REM_W-1:0] trial;
    logic                      ge_x, ge_y;

    assign trial = tfd_pkg::REM_W'(k_dmag) << (P - 1 - i);
    assign ge_x  = rem_x[i] >= trial;
    assign ge_y  = rem_y[i] >= trial;

    always_ff @(posedge clk) begin
      rem_x[i+1] <= ge_x ? (rem_x[i] - trial) : rem_x[i];
      rem_y[i+1] <= ge_y ? (rem_y[i] - trial) : rem_y[i];
      quo_x[i+1] <= quo_x[i] | (P'(ge_x) << (P - 1 - i));
      quo_y[i+1] <= quo_y[i] | (P'(ge_y) << (P - 1 - i));
      flg[i+1]   <= flg[i];
    end
  end

  // ---------------------------------------------------------------------------
  // Back end: saturate, heading products, squared distance, decision
  // ---------------------------------------------------------------------------
  logic signed [P-1:0]               cl_x, cl_y;          // clamp
  logic                              cl_dg;
  logic signed [tfd_pkg::MW-1:0]     ys, xc;              // products
  logic [tfd_pkg::DSQ_W-1:0]         xsq, ysq;
  logic signed [P-1:0]               mu_x, mu_y;
  logic                              mu_dg;
  logic [tfd_pkg::DSQ_W-1:0]         dsq;                 // decision
  logic                              turn_r, turn_l;
  logic signed [P-1:0]               dc_x, dc_y;
  logic                              dc_dg;

  always_ff @(posedge clk) begin
    cl_dg <= flg[P].degen;
    cl_x  <= flg[P].degen ? '0 : tfd_pkg::clamp_pos(quo_x[P], flg[P].ovf_x, flg[P].neg_x);
    cl_y  <= flg[P].degen ? '0 : tfd_pkg::clamp_pos(quo_y[P], flg[P].ovf_y, flg[P].neg_y);

    ys    <= tfd_pkg::MW'(cl_y) * tfd_pkg::MW'(tfd_pkg::SIN20_Q15);
    xc    <= tfd_pkg::MW'(cl_x) * tfd_pkg::MW'(tfd_pkg::COS20_Q15);
    xsq   <= tfd_pkg::DSQ_W'(tfd_pkg::DSQ_W'(cl_x) * tfd_pkg::DSQ_W'(cl_x));
    ysq   <= tfd_pkg::DSQ_W'(tfd_pkg::DSQ_W'(cl_y) * tfd_pkg::DSQ_W'(cl_y));
    mu_x  <= cl_x;
    mu_y  <= cl_y;
    mu_dg <= cl_dg;

    // band edges: equality is not a turn
    dsq    <= xsq + ysq;
    turn_r <= ((mu_x > 0) && (ys < xc)) || ((mu_x == 0) && (mu_y < 0));
    turn_l <= (mu_x < 0) && (ys < -xc);
    dc_x   <= mu_x;
    dc_y   <= mu_y;
    dc_dg  <= mu_dg;

    pos_x        <= dc_x;
    pos_y        <= dc_y;
    degenerate   <= dc_dg;
    beyond_limit <= dsq >= tfd_pkg::DSQ_W'(lim_sq);
    if (turn_r) begin
      action <= tfd_pkg::ACT_RIGHT;
    end else if (turn_l) begin
      action <= tfd_pkg::ACT_LEFT;
    end else if (dsq > tfd_pkg::DSQ_W'(fwd_sq)) begin
      action <= tfd_pkg::ACT_FWD;
    end else begin
      action <= tfd_pkg::ACT_HOLD;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_latency: assert property (@(posedge clk) disable iff (rst)
    acc |-> ##LAT done)
    else $error("request did not complete after fixed latency");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (done && degenerate) |-> (pos_x == '0 && pos_y == '0))
    else $error("degenerate result with nonzero position");

  a_right_side: assert property (@(posedge clk) disable iff (rst)
    (done && action == tfd_pkg::ACT_RIGHT) |-> (pos_x >= 0))
    else $error("turn right with negative x");

  a_left_side: assert property (@(posedge clk) disable iff (rst)
    (done && action == tfd_pkg::ACT_LEFT) |-> (pos_x < 0))
    else $error("turn left with non-negative x");

  a_reset_busy: assert property (@(posedge clk)
    rst |=> (busy && !done))
    else $error("busy low or done high right after reset");

endmodule

@@ verif/tfd_checker.sv @@
`timescale 1ns / 1ps

module tfd_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic                                busy,
  input  logic [tfd_pkg::RNG_W-1:0]           range_a,
  input  logic [tfd_pkg::RNG_W-1:0]           range_b,
  input  logic [tfd_pkg::RNG_W-1:0]           range_c,
  input  logic                                cfg_we,
  input  logic [tfd_pkg::IDX_W-1:0]           cfg_index,
  input  logic [tfd_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                done,
  input  logic signed [tfd_pkg::POS_BITS-1:0] pos_x,
  input  logic signed [tfd_pkg::POS_BITS-1:0] pos_y,
  input  logic                                degenerate,
  input  logic                                beyond_limit,
  input  logic [1:0]                          action,
  output int                                  errors,
  output int                                  pending
);

  typedef struct {
    logic signed [tfd_pkg::POS_BITS-1:0] x;
    logic signed [tfd_pkg::POS_BITS-1:0] y;
    logic                                dg;
    logic                                oor;
    logic [1:0]                          act;
  } fix_t;

  logic [tfd_pkg::CFG_W-1:0] cfg_r [8];
  fix_t                      fixes_q [$];

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic longint clamp_fix(input longint v);
    longint hi;
    hi = (longint'(1) <<< (tfd_pkg::POS_BITS - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic fix_t solve_fix(input logic [tfd_pkg::RNG_W-1:0] ra_i, rb_i, rc_i);
    longint ax, ay, bx, by, cx, cy, ra, rb, rc;
    longint a, b, c, d, e, f, det, x, y, dsq, fwd, lim;
    fix_t r;
    ax = $signed(cfg_r[tfd_pkg::REG_AX][tfd_pkg::ANC_W-1:0]);
    ay = $signed(cfg_r[tfd_pkg::REG_AY][tfd_pkg::ANC_W-1:0]);
    bx = $signed(cfg_r[tfd_pkg::REG_BX][tfd_pkg::ANC_W-1:0]);
    by = $signed(cfg_r[tfd_pkg::REG_BY][tfd_pkg::ANC_W-1:0]);
    cx = $signed(cfg_r[tfd_pkg::REG_CX][tfd_pkg::ANC_W-1:0]);
    cy = $signed(cfg_r[tfd_pkg::REG_CY][tfd_pkg::ANC_W-1:0]);
    fwd = longint'(cfg_r[tfd_pkg::REG_FWD]);
    lim = longint'(cfg_r[tfd_pkg::REG_RNG]);
    ra = longint'(ra_i); rb = longint'(rb_i); rc = longint'(rc_i);
    a = 2 * (bx - ax); b = 2 * (by - ay);
    c = ra*ra - rb*rb - ax*ax + bx*bx - ay*ay + by*by;
    d = 2 * (cx - bx); e = 2 * (cy - by);
    f = rb*rb - rc*rc - bx*bx + cx*cx - by*by + cy*cy;
    det = a*e - b*d;
    x = 0; y = 0;
    r.dg = (det == 0);
    if (!r.dg) begin
      // integer division truncates toward zero
      x = clamp_fix((c*e - f*b) / det);
      y = clamp_fix((a*f - d*c) / det);
    end
    dsq = x*x + y*y;
    if ((x > 0 && y*tfd_pkg::SIN20_Q15 < x*tfd_pkg::COS20_Q15) || (x == 0 && y < 0))
      r.act = tfd_pkg::ACT_RIGHT;
    else if (x < 0 && y*tfd_pkg::SIN20_Q15 < (-x)*tfd_pkg::COS20_Q15)
      r.act = tfd_pkg::ACT_LEFT;
    else if (dsq > fwd*fwd)
      r.act = tfd_pkg::ACT_FWD;
    else
      r.act = tfd_pkg::ACT_HOLD;
    r.oor = (dsq >= lim*lim);
    r.x = x[tfd_pkg::POS_BITS-1:0];
    r.y = y[tfd_pkg::POS_BITS-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    fix_t w;
    if (rst) begin
      cfg_r[tfd_pkg::REG_AX]  = 16'h7f06;   // -250 in 15 bits
      cfg_r[tfd_pkg::REG_AY]  = 16'd0;
      cfg_r[tfd_pkg::REG_BX]  = 16'd250;
      cfg_r[tfd_pkg::REG_BY]  = 16'd0;
      cfg_r[tfd_pkg::REG_CX]  = 16'd0;
      cfg_r[tfd_pkg::REG_CY]  = 16'h7dda;   // -550 in 15 bits
      cfg_r[tfd_pkg::REG_FWD] = 16'd2500;
      cfg_r[tfd_pkg::REG_RNG] = 16'd10000;
      fixes_q.delete();
      errors = 0;
    end else begin
      if (done) begin
        if (fixes_q.size() == 0) begin
          report("unexpected result", 1, 0);
        end else begin
          w = fixes_q.pop_front();
          if (pos_x !== w.x)          report("pos_x", pos_x, w.x);
          if (pos_y !== w.y)          report("pos_y", pos_y, w.y);
          if (degenerate !== w.dg)    report("degenerate", degenerate, w.dg);
          if (beyond_limit !== w.oor) report("beyond_limit", beyond_limit, w.oor);
          if (action !== w.act)       report("action", action, w.act);
        end
      end
      if (cfg_we) begin
        cfg_r[cfg_index] = (cfg_index == tfd_pkg::REG_FWD || cfg_index == tfd_pkg::REG_RNG) ?
                           cfg_data : {1'b0, cfg_data[tfd_pkg::ANC_W-1:0]};
      end
      if (start && !busy) fixes_q.push_back(solve_fix(range_a, range_b, range_c));
    end
    pending = fixes_q.size();
  end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;

  localparam int LATENCY    = tfd_pkg::POS_BITS + 12;
  localparam int WDOG_LIMIT = 20 * LATENCY + 200;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                start = 1'b0;
  logic                                busy;
  logic [tfd_pkg::RNG_W-1:0]           range_a = '0;
  logic [tfd_pkg::RNG_W-1:0]           range_b = '0;
  logic [tfd_pkg::RNG_W-1:0]           range_c = '0;
  logic                                cfg_we = 1'b0;
  logic [tfd_pkg::IDX_W-1:0]           cfg_index = '0;
  logic [tfd_pkg::CFG_W-1:0]           cfg_data = '0;
  logic                                done;
  logic signed [tfd_pkg::POS_BITS-1:0] pos_x;
  logic signed [tfd_pkg::POS_BITS-1:0] pos_y;
  logic                                degenerate;
  logic                                beyond_limit;
  logic [1:0]                          action;
  int                                  errors;
  int                                  pending;
  int                                  idle_run;

  // anchor set used to turn a point into ranges for well-formed requests
  int anc_x [3];
  int anc_y [3];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  trilateration_follow_decision_top uut (.*);

  tfd_checker chk (.*);

  // Watchdog: cycles with neither a request taken nor a result returned.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_run <= 0;
    end else begin
      idle_run <= idle_run + 1;
      if (idle_run >= WDOG_LIMIT) begin
        $display("timeout");
        $display("trilateration_follow_decision_top regression: fail");
        $finish;
      end
    end
  end

  // Hold start high until the request is taken; start stays up for a following request.
  task automatic send(input int a, b, c);
    @(negedge clk);
    start   <= 1'b1;
    range_a <= tfd_pkg::RNG_W'(a);
    range_b <= tfd_pkg::RNG_W'(b);
    range_c <= tfd_pkg::RNG_W'(c);
    do @(posedge clk); while (busy);
  endtask

  task automatic gap(input int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // Wait for every outstanding result, then for a further margin with no requests.
  task automatic drain();
    gap(1);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [tfd_pkg::IDX_W-1:0] idx, input int val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[tfd_pkg::CFG_W-1:0];
    if (idx <= tfd_pkg::REG_CY) begin
      anc_x[idx/2] = (idx % 2 == 0) ? val : anc_x[idx/2];
      anc_y[idx/2] = (idx % 2 == 1) ? val : anc_y[idx/2];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_cfg(input int ax, ay, bx, by, cx, cy, fwd, lim);
    drain();
    write_reg(tfd_pkg::REG_AX, ax);   write_reg(tfd_pkg::REG_AY, ay);
    write_reg(tfd_pkg::REG_BX, bx);   write_reg(tfd_pkg::REG_BY, by);
    write_reg(tfd_pkg::REG_CX, cx);   write_reg(tfd_pkg::REG_CY, cy);
    write_reg(tfd_pkg::REG_FWD, fwd); write_reg(tfd_pkg::REG_RNG, lim);
  endtask

  function automatic int range_to(input int i, input int px, py, input int noise);
    real dx, dy;
    int  r;
    dx = px - anc_x[i];
    dy = py - anc_y[i];
    r  = $rtoi($sqrt(dx*dx + dy*dy)) + noise;
    if (r < 0) r = 0;
    if (r > 131071) r = 131071;
    return r;
  endfunction

  // Mostly ranges measured from a real point, some pure noise.
  task automatic random_request(input bit idles);
    int px, py, nz;
    if ($urandom_range(0, 9) < 7) begin
      px = $urandom_range(0, 40000) - 20000;
      py = $urandom_range(0, 40000) - 20000;
      if ($urandom_range(0, 3) == 0) begin
        px = px / 8; py = py / 8;
      end
      nz = $urandom_range(0, 4) - 2;
      send(range_to(0, px, py, nz), range_to(1, px, py, nz), range_to(2, px, py, -nz));
    end else begin
      send($urandom, $urandom, $urandom);
    end
    if (idles && $urandom_range(0, 5) == 0) gap($urandom_range(1, 3));
  endtask

  task automatic random_anchors();
    set_cfg($urandom_range(0, 8000) - 4000, $urandom_range(0, 8000) - 4000,
            $urandom_range(0, 8000) - 4000, $urandom_range(0, 8000) - 4000,
            $urandom_range(0, 8000) - 4000, $urandom_range(0, 8000) - 4000,
            $urandom_range(0, 65535), $urandom_range(0, 65535));
  endtask

  initial begin
    anc_x = '{-250, 250, 0};
    anc_y = '{0, 0, -550};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset defaults, range extremes, the origin, band edges nearby.
    send(0, 0, 0);
    send(1, 1, 1);
    send(99999, 99999, 99999);
    send(131071, 0, 131071);
    send(0, 131071, 0);
    send(range_to(0, 0, 0, 0), range_to(1, 0, 0, 0), range_to(2, 0, 0, 0));
    send(range_to(0, 0, 3000, 0), range_to(1, 0, 3000, 0), range_to(2, 0, 3000, 0));
    send(range_to(0, 0, -3000, 0), range_to(1, 0, -3000, 0), range_to(2, 0, -3000, 0));
    send(range_to(0, 1026, 2819, 0), range_to(1, 1026, 2819, 0),
         range_to(2, 1026, 2819, 0));
    send(range_to(0, -1026, 2819, 0), range_to(1, -1026, 2819, 0),
         range_to(2, -1026, 2819, 0));
    send(range_to(0, 20000, 0, 0), range_to(1, 20000, 0, 0), range_to(2, 20000, 0, 0));

    // Degenerate: all anchors coincide; limit zero flags the origin as beyond the limit.
    set_cfg(100, 100, 100, 100, 100, 100, 0, 0);
    send(5000, 17, 99999);
    send(0, 0, 0);
    // Collinear anchors, limits at the top.
    set_cfg(-16384, 0, 0, 0, 16383, 0, 65535, 65535);
    send(1000, 2000, 3000);
    // Anchor extremes, tight spacing drives saturation.
    set_cfg(-16384, -16384, -16383, -16384, -16384, -16383, 0, 65535);
    send(131071, 0, 65535);
    send(0, 131071, 131071);
    set_cfg(16383, 16383, -16384, 16383, 16383, -16384, 1, 1);
    send(131071, 131071, 0);
    send(40000, 9000, 1);

    // Random body across several settings, idling in bursts.
    for (int ph = 0; ph < 5; ph++) begin
      if (ph == 0) set_cfg(-250, 0, 250, 0, 0, -550, 2500, 10000);
      else random_anchors();
      for (int i = 0; i < 180; i++) begin
        random_request(1'b1);
        // sender hold-off: let the pipe empty completely once
        if (ph == 2 && i == 90) begin
          gap(1);
          while (pending != 0) @(posedge clk);
        end
      end
    end
    // Closing stretch back-to-back, no idling.
    random_anchors();
    for (int i = 0; i < 120; i++) random_request(1'b0);

    gap(1);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("trilateration_follow_decision_top regression: pass");
    end else begin
      $display("trilateration_follow_decision_top regression: fail");
    end
    $finish;
  end

endmodule
